[design/cscl_pkg.sv]
// Shared definitions for the Cohen-Sutherland line clipper unit.
// Holds the microcode format, the microcode ROM, register indexes and outcode bits.
// No dependencies; every other design file imports this package.
package cscl_pkg;

    // Default coordinate width and configuration index width.
    localparam int COORD_BITS_DEF = 10;
    localparam int CFG_IDX_BITS   = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_A_X = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_B_X = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_A_Y = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_B_Y = CFG_IDX_BITS'(3);

    // Outcode bits.
    localparam logic [3:0] OC_LEFT   = 4'd1;
    localparam logic [3:0] OC_RIGHT  = 4'd2;
    localparam logic [3:0] OC_BOTTOM = 4'd4;
    localparam logic [3:0] OC_TOP    = 4'd8;

    // Microprogram steps.
    typedef enum logic [2:0] {
        ST_WAIT,
        ST_DECIDE,
        ST_SETUP,
        ST_MUL,
        ST_DSTART,
        ST_DWAIT,
        ST_UPDATE,
        ST_EMIT
    } step_t;

    // Branch conditions tested by the sequencer.
    typedef enum logic [2:0] {
        CND_ALWAYS,
        CND_IN_ACCEPT,
        CND_DECIDED,
        CND_DIV_BUSY,
        CND_OUT_FREE
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        cond_t cond;
        step_t tgt_true;
        step_t tgt_false;
        logic  in_ready;
        logic  setup;
        logic  mul;
        logic  div_start;
        logic  update;
        logic  emit;
    } ucode_t;

    // Conditions reported back to the sequencer.
    typedef struct packed {
        logic in_accept;
        logic decided;
        logic div_busy;
        logic out_free;
    } status_t;

    // Microcode ROM: one control word per step.
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        w = '0;
        case (s)
            ST_WAIT: begin
                w.cond = CND_IN_ACCEPT; w.tgt_true = ST_DECIDE; w.tgt_false = ST_WAIT;
                w.in_ready = 1'b1;
            end
            ST_DECIDE: begin
                w.cond = CND_DECIDED; w.tgt_true = ST_EMIT; w.tgt_false = ST_SETUP;
            end
            ST_SETUP: begin
                w.cond = CND_ALWAYS; w.tgt_true = ST_MUL; w.tgt_false = ST_MUL;
                w.setup = 1'b1;
            end
            ST_MUL: begin
                w.cond = CND_ALWAYS; w.tgt_true = ST_DSTART; w.tgt_false = ST_DSTART;
                w.mul = 1'b1;
            end
            ST_DSTART: begin
                w.cond = CND_ALWAYS; w.tgt_true = ST_DWAIT; w.tgt_false = ST_DWAIT;
                w.div_start = 1'b1;
            end
            ST_DWAIT: begin
                w.cond = CND_DIV_BUSY; w.tgt_true = ST_DWAIT; w.tgt_false = ST_UPDATE;
            end
            ST_UPDATE: begin
                w.cond = CND_ALWAYS; w.tgt_true = ST_DECIDE; w.tgt_false = ST_DECIDE;
                w.update = 1'b1;
            end
            ST_EMIT: begin
                w.cond = CND_OUT_FREE; w.tgt_true = ST_WAIT; w.tgt_false = ST_EMIT;
                w.emit = 1'b1;
            end
            default: begin
                w.cond = CND_ALWAYS; w.tgt_true = ST_WAIT; w.tgt_false = ST_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

[design/cscl_seq.sv]
// Microcode sequencer: step counter, control ROM lookup and conditional branch.
// Depends on cscl_pkg for the control word, status and step types.
module cscl_seq
    import cscl_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output ucode_t  ctrl
);

    step_t pc_reg;
    step_t pc_next;
    logic  cond_hit;

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // Fetch the control word and pick the next step.
    always_comb begin
        ctrl = ucode_rom(pc_reg);
        case (ctrl.cond)
            CND_ALWAYS:    cond_hit = 1'b1;
            CND_IN_ACCEPT: cond_hit = status.in_accept;
            CND_DECIDED:   cond_hit = status.decided;
            CND_DIV_BUSY:  cond_hit = status.div_busy;
            CND_OUT_FREE:  cond_hit = status.out_free;
            default:       cond_hit = 1'b1;
        endcase
        pc_next = cond_hit ? ctrl.tgt_true : ctrl.tgt_false;
    end

endmodule

[design/cscl_div.sv]
// Serial unsigned divider: one restoring quotient bit per cycle.
// The dividend must satisfy dividend < divisor * 2**COORD_BITS; depends on cscl_pkg.
module cscl_div
    import cscl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [2*COORD_BITS-1:0] dividend,
    input  logic [COORD_BITS-1:0]   divisor,
    output logic                    busy,
    output logic [COORD_BITS-1:0]   quotient
);

    localparam int N  = COORD_BITS;
    localparam int CW = $clog2(N + 1);

    logic [CW-1:0] cnt_reg;
    logic [N-1:0]  rem_reg;
    logic [N-1:0]  dvd_reg;
    logic [N:0]    trial;
    logic [N:0]    diff;
    logic          ge;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb begin
        trial = {rem_reg, dvd_reg[N-1]};
        diff  = trial - {1'b0, divisor};
        ge    = trial >= {1'b0, divisor};
    end

    // Iteration counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CW'(N);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    // Remainder and dividend/quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[2*N-1:N];
            dvd_reg <= dividend[N-1:0];
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? diff[N-1:0] : trial[N-1:0];
            dvd_reg <= {dvd_reg[N-2:0], ge};
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = dvd_reg;

endmodule

[design/cscl_dp.sv]
// Clipper datapath: window registers, endpoint registers, outcodes, edge setup,
// multiplier, endpoint update and the result register. Depends on cscl_pkg.
module cscl_dp
    import cscl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ucode_t                  ctrl,
    input  logic                    in_accept,
    input  logic [COORD_BITS-1:0]   in_start_x,
    input  logic [COORD_BITS-1:0]   in_start_y,
    input  logic [COORD_BITS-1:0]   in_end_x,
    input  logic [COORD_BITS-1:0]   in_end_y,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]   cfg_data,
    input  logic [COORD_BITS-1:0]   div_quot,
    output logic [2*COORD_BITS-1:0] div_dividend,
    output logic [COORD_BITS-1:0]   div_divisor,
    output logic                    decided,
    output logic                    out_free,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic                    out_visible,
    output logic [COORD_BITS-1:0]   out_start_x,
    output logic [COORD_BITS-1:0]   out_start_y,
    output logic [COORD_BITS-1:0]   out_end_x,
    output logic [COORD_BITS-1:0]   out_end_y
);

    localparam int N  = COORD_BITS;
    localparam int PW = 2 * COORD_BITS;

    // Magnitude of an (N+1)-bit signed difference; it always fits N bits here.
    function automatic logic [N-1:0] mag(input logic [N:0] v);
        logic [N:0] v_neg;
        v_neg = -v;
        return v[N] ? v_neg[N-1:0] : v[N-1:0];
    endfunction

    logic [N-1:0] corner_ax_reg, corner_bx_reg, corner_ay_reg, corner_by_reg;
    logic [N-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [N-1:0] e_left, e_right, e_bottom, e_top;
    logic [3:0]   c1, c2, co;

    logic [N:0]   sdx, sdy, mul_a, off, den;
    logic [N-1:0] edge_val;
    logic         horiz;

    logic         sel_p1_reg, horiz_reg, neg_reg;
    logic [N-1:0] edge_reg, a_mag_reg, off_mag_reg, den_mag_reg;
    logic [PW-1:0] prod_reg;

    logic [N-1:0] q;
    logic [N:0]   q_s;
    logic [N-1:0] base;
    logic [N:0]   sum;
    logic [N-1:0] nx, ny;

    logic         m_tvalid_reg, vis_reg;
    logic [N-1:0] o_sx_reg, o_sy_reg, o_ex_reg, o_ey_reg;
    logic         vis_now;

    // Window corner registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_ax_reg <= '0;
            corner_bx_reg <= '0;
            corner_ay_reg <= '0;
            corner_by_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CORNER_A_X: corner_ax_reg <= cfg_data;
                REG_CORNER_B_X: corner_bx_reg <= cfg_data;
                REG_CORNER_A_Y: corner_ay_reg <= cfg_data;
                REG_CORNER_B_Y: corner_by_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sorted window edges and the outcodes of both endpoints.
    always_comb begin
        e_left   = (corner_ax_reg < corner_bx_reg) ? corner_ax_reg : corner_bx_reg;
        e_right  = (corner_ax_reg < corner_bx_reg) ? corner_bx_reg : corner_ax_reg;
        e_bottom = (corner_ay_reg < corner_by_reg) ? corner_ay_reg : corner_by_reg;
        e_top    = (corner_ay_reg < corner_by_reg) ? corner_by_reg : corner_ay_reg;
        c1 = ((y1_reg > e_top)    ? OC_TOP    : 4'd0) |
             ((y1_reg < e_bottom) ? OC_BOTTOM : 4'd0) |
             ((x1_reg > e_right)  ? OC_RIGHT  : 4'd0) |
             ((x1_reg < e_left)   ? OC_LEFT   : 4'd0);
        c2 = ((y2_reg > e_top)    ? OC_TOP    : 4'd0) |
             ((y2_reg < e_bottom) ? OC_BOTTOM : 4'd0) |
             ((x2_reg > e_right)  ? OC_RIGHT  : 4'd0) |
             ((x2_reg < e_left)   ? OC_LEFT   : 4'd0);
        vis_now = (c1 == 4'd0) && (c2 == 4'd0);
        decided = vis_now || ((c1 & c2) != 4'd0);
    end

    // Edge choice in bottom, top, left, right priority and the operands of the cut.
    always_comb begin
        co  = (c1 != 4'd0) ? c1 : c2;
        sdx = {1'b0, x2_reg} - {1'b0, x1_reg};
        sdy = {1'b0, y2_reg} - {1'b0, y1_reg};
        if ((co & OC_BOTTOM) != 4'd0) begin
            edge_val = e_bottom;
        end else if ((co & OC_TOP) != 4'd0) begin
            edge_val = e_top;
        end else if ((co & OC_LEFT) != 4'd0) begin
            edge_val = e_left;
        end else begin
            edge_val = e_right;
        end
        horiz = ((co & (OC_BOTTOM | OC_TOP)) != 4'd0);
        if (horiz) begin
            mul_a = sdx;
            off   = {1'b0, edge_val} - {1'b0, y1_reg};
            den   = sdy;
        end else begin
            mul_a = sdy;
            off   = {1'b0, edge_val} - {1'b0, x1_reg};
            den   = sdx;
        end
    end

    // Setup register: magnitudes and the sign of the quotient.
    always_ff @(posedge aclk) begin
        if (ctrl.setup) begin
            sel_p1_reg  <= c1 != 4'd0;
            horiz_reg   <= horiz;
            edge_reg    <= edge_val;
            neg_reg     <= mul_a[N] ^ off[N] ^ den[N];
            a_mag_reg   <= mag(mul_a);
            off_mag_reg <= mag(off);
            den_mag_reg <= mag(den);
        end
    end

    // Product register feeding the divider.
    always_ff @(posedge aclk) begin
        if (ctrl.mul) begin
            prod_reg <= PW'(a_mag_reg) * PW'(off_mag_reg);
        end
    end

    assign div_dividend = prod_reg;
    assign div_divisor  = den_mag_reg;

    // New endpoint: the base coordinate plus the signed, truncated quotient.
    always_comb begin
        q    = (den_mag_reg == '0) ? '0 : div_quot;
        q_s  = neg_reg ? -{1'b0, q} : {1'b0, q};
        base = horiz_reg ? x1_reg : y1_reg;
        sum  = {1'b0, base} + q_s;
        if (horiz_reg) begin
            nx = sum[N-1:0];
            ny = edge_reg;
        end else begin
            nx = edge_reg;
            ny = sum[N-1:0];
        end
    end

    // Endpoint registers: loaded from the input beat, then moved onto edges.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            x1_reg <= in_start_x;
            y1_reg <= in_start_y;
            x2_reg <= in_end_x;
            y2_reg <= in_end_y;
        end else if (ctrl.update) begin
            if (sel_p1_reg) begin
                x1_reg <= nx;
                y1_reg <= ny;
            end else begin
                x2_reg <= nx;
                y2_reg <= ny;
            end
        end
    end

    // Result register; a rejected segment reports all zero coordinates.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.emit && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit && out_free) begin
            vis_reg  <= vis_now;
            o_sx_reg <= vis_now ? x1_reg : '0;
            o_sy_reg <= vis_now ? y1_reg : '0;
            o_ex_reg <= vis_now ? x2_reg : '0;
            o_ey_reg <= vis_now ? y2_reg : '0;
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign out_visible = vis_reg;
    assign out_start_x = o_sx_reg;
    assign out_start_y = o_sy_reg;
    assign out_end_x   = o_ex_reg;
    assign out_end_y   = o_ey_reg;

endmodule

[design/cohen_sutherland_line_clipper_unit.sv]
// Cohen-Sutherland line clipper. One input beat carries a segment; one result beat
// returns the visible flag (tuser) and the clipped endpoints, all zero when the segment
// is rejected. The window comes from two diagonal corners written on the cfg channel.
// Work is run by a microcoded sequencer: a step to take the beat, one outcode test
// per pass, and for each cut (at most four) setup, multiply, divider start, a wait
// on the serial divider and an update, then a step to hand the result to the output
// register. One segment is worked on at a time, up to that hand-off.
// A new segment is taken while the previous result still waits in the output register.
// Depends on cscl_pkg, cscl_seq, cscl_dp and cscl_div.
module cohen_sutherland_line_clipper_unit
    import cscl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0: start_x, start_y, end_x, end_y.
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    // Result stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Fields from bit 0: clip_start_x, clip_start_y, clip_end_x, clip_end_y.
    output logic [((4*COORD_BITS+7)/8)*8-1:0]      m_tdata,
    // Fields from bit 0: visible.
    output logic                                   m_tuser,
    // Configuration write channel.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]                cfg_index,
    input  logic [COORD_BITS-1:0]                  cfg_data
);

    localparam int N  = COORD_BITS;
    localparam int TW = ((4 * COORD_BITS + 7) / 8) * 8;

    ucode_t          ctrl;
    status_t         status;
    logic            in_accept;
    logic            decided;
    logic            out_free;
    logic            div_busy;
    logic [2*N-1:0]  div_dividend;
    logic [N-1:0]    div_divisor;
    logic [N-1:0]    div_quot;
    logic [N-1:0]    o_sx, o_sy, o_ex, o_ey;

    assign s_tready  = ctrl.in_ready;
    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && ctrl.in_ready;

    // Conditions seen by the sequencer.
    always_comb begin
        status.in_accept = in_accept;
        status.decided   = decided;
        status.div_busy  = div_busy;
        status.out_free  = out_free;
    end

    cscl_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    cscl_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .in_accept    (in_accept),
        .in_start_x   (s_tdata[N-1:0]),
        .in_start_y   (s_tdata[2*N-1:N]),
        .in_end_x     (s_tdata[3*N-1:2*N]),
        .in_end_y     (s_tdata[4*N-1:3*N]),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .div_quot     (div_quot),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .decided      (decided),
        .out_free     (out_free),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .out_visible  (m_tuser),
        .out_start_x  (o_sx),
        .out_start_y  (o_sy),
        .out_end_x    (o_ex),
        .out_end_y    (o_ey)
    );

    cscl_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Pack the result beat, padded with zeros to whole bytes.
    assign m_tdata = TW'({o_ey, o_ex, o_sy, o_sx});

    // A rejected segment carries only zero coordinates.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("rejected result with nonzero coordinates");

    // The divider is never left running while a new segment can be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("divider busy while waiting for input");

    // After a segment is taken the block works on it before taking another.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second segment taken in back-to-back cycles");

endmodule

[sim/cscl_checker.sv]
// Checker for the Cohen-Sutherland line clipper unit: watches the configuration,
// segment and result channels, predicts each clipped segment and compares it.
// Depends on cscl_pkg for the coordinate width, register indexes and outcode bits.
module cscl_checker
    import cscl_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF,
    parameter int DW = ((4 * CB + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [DW-1:0]           s_tdata,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [DW-1:0]           m_tdata,
    input  logic                    m_tuser,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CB-1:0]           cfg_data,
    output int                      mismatch_count,
    output int                      results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Safety bound on the clipping loop; real segments settle in four cuts or fewer.
    localparam int MAX_PASSES = 32;
    localparam logic [3:0] OC_NONE = 4'd0;

    typedef struct packed {
        logic          visible;
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
    } clip_result_t;

    // Window corners as last written on the configuration channel.
    logic [CB-1:0] corner_ax = '0;
    logic [CB-1:0] corner_bx = '0;
    logic [CB-1:0] corner_ay = '0;
    logic [CB-1:0] corner_by = '0;

    clip_result_t clip_expected[$];

    initial begin
        mismatch_count  = 0;
        results_pending = 0;
    end

    function automatic logic [3:0] region_code(input longint x, input longint y,
                                               input longint left, input longint right,
                                               input longint bottom, input longint top);
        logic [3:0] code;
        code = OC_NONE;
        if (y > top) code |= OC_TOP;
        if (y < bottom) code |= OC_BOTTOM;
        if (x > right) code |= OC_RIGHT;
        if (x < left) code |= OC_LEFT;
        return code;
    endfunction

    // Signed division truncating toward zero; a zero divisor yields zero.
    function automatic longint quotient(input longint num, input longint den);
        return (den == 0) ? 64'sd0 : num / den;
    endfunction

    // Clips one segment against the window sorted out of the two corners.
    function automatic clip_result_t clip_segment(input longint x1_in, input longint y1_in,
                                                  input longint x2_in, input longint y2_in);
        longint ax, bx, ay, by;
        longint left, right, bottom, top;
        longint x1, y1, x2, y2, nx, ny;
        logic [3:0] c1, c2, co;
        int passes;
        bit visible, settled;
        clip_result_t res;
        ax = corner_ax;
        bx = corner_bx;
        ay = corner_ay;
        by = corner_by;
        left   = (ax < bx) ? ax : bx;
        right  = (ax < bx) ? bx : ax;
        bottom = (ay < by) ? ay : by;
        top    = (ay < by) ? by : ay;
        x1 = x1_in;
        y1 = y1_in;
        x2 = x2_in;
        y2 = y2_in;
        c1 = region_code(x1, y1, left, right, bottom, top);
        c2 = region_code(x2, y2, left, right, bottom, top);
        visible = 1'b0;
        settled = 1'b0;
        passes  = 0;

        while (!settled && passes < MAX_PASSES) begin
            if (c1 == OC_NONE && c2 == OC_NONE) begin
                visible = 1'b1;
                settled = 1'b1;
            end else if ((c1 & c2) != OC_NONE) begin
                settled = 1'b1;
            end else begin
                // Move the first outside endpoint onto an edge: bottom, top, left, right.
                co = (c1 != OC_NONE) ? c1 : c2;
                if ((co & OC_BOTTOM) != OC_NONE) begin
                    nx = x1 + quotient((x2 - x1) * (bottom - y1), y2 - y1);
                    ny = bottom;
                end else if ((co & OC_TOP) != OC_NONE) begin
                    nx = x1 + quotient((x2 - x1) * (top - y1), y2 - y1);
                    ny = top;
                end else if ((co & OC_LEFT) != OC_NONE) begin
                    ny = y1 + quotient((y2 - y1) * (left - x1), x2 - x1);
                    nx = left;
                end else begin
                    ny = y1 + quotient((y2 - y1) * (right - x1), x2 - x1);
                    nx = right;
                end
                if (co == c1) begin
                    x1 = nx;
                    y1 = ny;
                    c1 = region_code(x1, y1, left, right, bottom, top);
                end else begin
                    x2 = nx;
                    y2 = ny;
                    c2 = region_code(x2, y2, left, right, bottom, top);
                end
            end
            passes++;
        end

        res = '0;
        if (visible) begin
            res.visible = 1'b1;
            res.sx = x1[CB-1:0];
            res.sy = y1[CB-1:0];
            res.ex = x2[CB-1:0];
            res.ey = y2[CB-1:0];
        end
        return res;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Track configuration, compare result beats, and queue a prediction per segment beat.
    always @(posedge aclk) begin : monitor
        clip_result_t want;
        clip_result_t got;
        if (!aresetn) begin
            corner_ax <= '0;
            corner_bx <= '0;
            corner_ay <= '0;
            corner_by <= '0;
            clip_expected.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CORNER_A_X: corner_ax <= cfg_data;
                    REG_CORNER_B_X: corner_bx <= cfg_data;
                    REG_CORNER_A_Y: corner_ay <= cfg_data;
                    REG_CORNER_B_Y: corner_by <= cfg_data;
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got.visible = m_tuser;
                got.sx = m_tdata[CB-1:0];
                got.sy = m_tdata[2*CB-1:CB];
                got.ex = m_tdata[3*CB-1:2*CB];
                got.ey = m_tdata[4*CB-1:3*CB];
                if (clip_expected.size() == 0) begin
                    $error("result beat arrived with no segment outstanding");
                    mismatch_count++;
                end else begin
                    want = clip_expected.pop_front();
                    check_field("visible", want.visible, got.visible);
                    check_field("clip_start_x", want.sx, got.sx);
                    check_field("clip_start_y", want.sy, got.sy);
                    check_field("clip_end_x", want.ex, got.ex);
                    check_field("clip_end_y", want.ey, got.ey);
                end
            end

            if (s_tvalid && s_tready) begin
                clip_expected.push_back(clip_segment(s_tdata[CB-1:0], s_tdata[2*CB-1:CB],
                                                     s_tdata[3*CB-1:2*CB],
                                                     s_tdata[4*CB-1:3*CB]));
            end
        end
        results_pending <= clip_expected.size();
    end

endmodule

[sim/tb_cohen_sutherland_line_clipper_unit.sv]
// Top of the line clipper testbench: clock, reset, window writes, segment stimulus
// with bursts and gaps, a stalling result sink and the final verdict.
// Depends on cscl_pkg, the cohen_sutherland_line_clipper_unit RTL and cscl_checker.
module tb_cohen_sutherland_line_clipper_unit
    import cscl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB              = COORD_BITS_DEF;
    localparam int DW              = ((4 * CB + 7) / 8) * 8;
    localparam int COORD_MAX       = (1 << CB) - 1;
    localparam int NUM_CORNER_REGS = 4;
    localparam int HALF_PERIOD     = 5;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 100;
    localparam int TIMEOUT_NS      = 10_000_000;

    typedef struct packed {
        logic [CB-1:0] ey;
        logic [CB-1:0] ex;
        logic [CB-1:0] sy;
        logic [CB-1:0] sx;
    } segment_t;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_MOSTLY,
        SINK_SPARSE
    } sink_mode_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [DW-1:0]           s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [DW-1:0]           m_tdata;
    logic                    m_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CB-1:0]           cfg_data  = '0;

    int mismatch_count;
    int results_pending;

    // Set by the stimulus to ask the sink for one long hold-off.
    bit hold_off_req = 1'b0;

    // Current window edges, used only to aim stimulus near the boundary.
    int win_left   = 0;
    int win_right  = 0;
    int win_bottom = 0;
    int win_top    = 0;

    segment_t seg_queue[$];

    cohen_sutherland_line_clipper_unit #(
        .COORD_BITS(CB)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cscl_checker #(
        .CB(CB)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL cohen_sutherland_line_clipper_unit");
        $finish;
    end

    // Result sink: alternates stall patterns and honors a single long hold-off.
    initial begin : result_sink
        sink_mode_t mode;
        int run;
        int tick;
        tick = 0;
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            mode = sink_mode_t'($urandom_range(0, 3));
            run  = $urandom_range(4, 64);
            repeat (run) begin
                case (mode)
                    SINK_OPEN:   m_tready <= 1'b1;
                    SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    SINK_MOSTLY: m_tready <= (tick % 4) != 0;
                    default:     m_tready <= (tick % 4) == 0;
                endcase
                tick++;
                @(posedge aclk);
            end
        end
    end

    // Writes all four corners, then a write to an unused index that must be ignored.
    task automatic apply_window(input int ax, input int bx, input int ay, input int by);
        logic [CFG_IDX_BITS-1:0] reg_idx[5];
        int reg_val[5];
        reg_idx[0] = REG_CORNER_A_X;
        reg_idx[1] = REG_CORNER_B_X;
        reg_idx[2] = REG_CORNER_A_Y;
        reg_idx[3] = REG_CORNER_B_Y;
        reg_idx[4] = CFG_IDX_BITS'($urandom_range(NUM_CORNER_REGS, (1 << CFG_IDX_BITS) - 1));
        reg_val[0] = ax;
        reg_val[1] = bx;
        reg_val[2] = ay;
        reg_val[3] = by;
        reg_val[4] = $urandom_range(0, COORD_MAX);
        win_left   = (ax < bx) ? ax : bx;
        win_right  = (ax < bx) ? bx : ax;
        win_bottom = (ay < by) ? ay : by;
        win_top    = (ay < by) ? by : ay;
        cfg_valid <= 1'b1;
        for (int k = 0; k < 5; k++) begin
            cfg_index <= reg_idx[k];
            cfg_data  <= CB'(reg_val[k]);
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic add_segment(input int sx, input int sy, input int ex, input int ey);
        segment_t seg;
        seg.sx = CB'(sx);
        seg.sy = CB'(sy);
        seg.ex = CB'(ex);
        seg.ey = CB'(ey);
        seg_queue.push_back(seg);
    endtask

    // Coordinate biased toward the window edges, the extremes and the interior.
    function automatic int pick_coord(input int lo, input int hi);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, COORD_MAX);
            4:          v = lo + int'($urandom_range(0, 4)) - 2;
            5:          v = hi + int'($urandom_range(0, 4)) - 2;
            6:          v = $urandom_range(0, 1) ? COORD_MAX : 0;
            default:    v = $urandom_range(lo, hi);
        endcase
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return v;
    endfunction

    task automatic add_random_segments(input int count);
        int sx, sy, ex, ey;
        repeat (count) begin
            sx = pick_coord(win_left, win_right);
            sy = pick_coord(win_bottom, win_top);
            ex = pick_coord(win_left, win_right);
            ey = pick_coord(win_bottom, win_top);
            // Some horizontal, vertical and single-point segments.
            case ($urandom_range(0, 19))
                0, 1: ey = sy;
                2, 3: ex = sx;
                4: begin
                    ex = sx;
                    ey = sy;
                end
                default: ;
            endcase
            add_segment(sx, sy, ex, ey);
        end
    endtask

    // Sends every queued segment in bursts of random length with random gaps.
    task automatic send_segments();
        int burst;
        int gap;
        burst = 0;
        while (seg_queue.size() > 0) begin
            if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst = $urandom_range(1, 24);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= DW'(seg_queue[0]);
            do @(posedge aclk); while (!s_tready);
            void'(seg_queue.pop_front());
            burst--;
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_results_done();
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int rx, ry;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset window is the single point at the origin.
        add_segment(0, 0, 0, 0);
        add_segment(0, 0, COORD_MAX, COORD_MAX);
        add_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        add_segment(COORD_MAX, 0, 0, COORD_MAX);
        send_segments();
        wait_results_done();

        // Corners given out of order so the block has to sort them.
        apply_window(700, 100, 200, 800);
        add_segment(150, 250, 650, 750);
        add_segment(0, 0, COORD_MAX, COORD_MAX);
        add_segment(COORD_MAX, 0, 0, COORD_MAX);
        add_segment(0, 500, COORD_MAX, 500);
        add_segment(400, 0, 400, COORD_MAX);
        add_segment(0, 0, 50, COORD_MAX);
        add_segment(800, 0, COORD_MAX, COORD_MAX);
        add_segment(0, 0, COORD_MAX, 100);
        add_segment(0, 900, COORD_MAX, COORD_MAX);
        // Both ends outside on different sides, line passes beside the corner.
        add_segment(0, 700, 300, COORD_MAX);
        add_segment(100, 200, 700, 800);
        add_segment(400, 400, 400, 400);
        add_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        add_segment(400, 500, COORD_MAX, 0);
        send_segments();
        wait_results_done();

        // Random phases, each under its own window.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            rx = $urandom_range(0, COORD_MAX);
            ry = $urandom_range(0, COORD_MAX);
            case (phase)
                0: apply_window(COORD_MAX, 0, 0, COORD_MAX);
                1: apply_window(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
                2: apply_window(rx, rx, ry, $urandom_range(0, COORD_MAX));
                3: apply_window(rx, $urandom_range(0, COORD_MAX), ry, ry);
                default: apply_window($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            endcase
            if (phase == PRESSURE_PHASE) hold_off_req = 1'b1;
            add_random_segments(ITEMS_PER_PHASE);
            send_segments();
            wait_results_done();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS cohen_sutherland_line_clipper_unit");
        end else begin
            $display("FAIL cohen_sutherland_line_clipper_unit");
        end
        $finish;
    end

endmodule
